// ===== design/sia_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the signed integer ALU.
// Used by every module of the design; it depends on nothing else.
package sia_pkg;

    localparam int DataWidth = 64;
    localparam int ShiftBits = 6;
    localparam int DivSteps  = DataWidth;
    localparam int InBytes   = (4 + 2 * DataWidth + 7) / 8;
    localparam int OutBytes  = (DataWidth + 2 + 7) / 8;

    typedef logic [DataWidth-1:0] word_t;

    typedef enum logic [3:0] {
        OP_MUL = 4'd0,
        OP_DIV = 4'd1,
        OP_REM = 4'd2,
        OP_ADD = 4'd3,
        OP_SUB = 4'd4,
        OP_SHL = 4'd5,
        OP_SAR = 4'd6,
        OP_LT  = 4'd7,
        OP_LE  = 4'd8,
        OP_GT  = 4'd9,
        OP_GE  = 4'd10,
        OP_EQ  = 4'd11,
        OP_NE  = 4'd12,
        OP_AND = 4'd13,
        OP_XOR = 4'd14,
        OP_OR  = 4'd15
    } op_t;

    typedef enum logic [1:0] {
        FAULT_NONE     = 2'd0,
        FAULT_DIV_ZERO = 2'd1,
        FAULT_OVERFLOW = 2'd2
    } fault_t;

    // Item as it travels through the divider stages.
    typedef struct packed {
        logic   valid;
        op_t    op;
        fault_t fault;
        logic   neg_q;
        logic   neg_r;
        word_t  res;
        word_t  rem;
        word_t  quo;
        word_t  dsr;
    } div_t;

endpackage

// ===== design/sia_front.sv =====
`timescale 1ns / 1ps
// Front end of the ALU: decode, the simple operations, partial products
// of the multiplier and the setup of the divider, in two register stages.
// Depends on sia_pkg.
module sia_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  sia_pkg::op_t               in_op,
    input  sia_pkg::word_t             in_lhs,
    input  sia_pkg::word_t             in_rhs,
    output sia_pkg::div_t              out_item
);
    import sia_pkg::*;

    localparam int Half = DataWidth / 2;

    logic             a_valid_reg;
    op_t              a_op_reg;
    fault_t           a_fault_reg;
    logic             a_neg_q_reg;
    logic             a_neg_r_reg;
    word_t            a_simple_reg;
    word_t            a_mag_a_reg;
    word_t            a_mag_b_reg;
    word_t            a_pp_ll_reg;
    logic [Half-1:0]  a_pp_lh_reg;
    logic [Half-1:0]  a_pp_hl_reg;

    fault_t           fault_next;
    word_t            simple_next;
    word_t            pp_ll_next;
    logic [Half-1:0]  pp_lh_next;
    logic [Half-1:0]  pp_hl_next;
    logic             lt;
    logic             gt;
    logic             eq;
    logic [ShiftBits-1:0] cnt;
    word_t            min_val;

    logic             b_valid_reg;
    div_t             b_item_reg;
    div_t             b_item_next;

    assign lt      = $signed(in_lhs) < $signed(in_rhs);
    assign gt      = $signed(in_lhs) > $signed(in_rhs);
    assign eq      = in_lhs == in_rhs;
    assign cnt     = in_rhs[ShiftBits-1:0];
    assign min_val = {1'b1, {(DataWidth-1){1'b0}}};

    assign pp_ll_next = word_t'(in_lhs[Half-1:0] * in_rhs[Half-1:0]);
    assign pp_lh_next = Half'(in_lhs[Half-1:0] * in_rhs[DataWidth-1:Half]);
    assign pp_hl_next = Half'(in_lhs[DataWidth-1:Half] * in_rhs[Half-1:0]);

    always_comb
    begin
        fault_next = FAULT_NONE;
        if (in_op == OP_DIV || in_op == OP_REM)
        begin
            if (in_rhs == '0)
            begin
                fault_next = FAULT_DIV_ZERO;
            end
            else if (in_lhs == min_val && in_rhs == '1)
            begin
                fault_next = FAULT_OVERFLOW;
            end
        end
    end

    always_comb
    begin
        unique case (in_op)
            OP_ADD:  simple_next = in_lhs + in_rhs;
            OP_SUB:  simple_next = in_lhs - in_rhs;
            OP_SHL:  simple_next = in_lhs << cnt;
            OP_SAR:  simple_next = word_t'($signed(in_lhs) >>> cnt);
            OP_LT:   simple_next = word_t'(lt);
            OP_LE:   simple_next = word_t'(!gt);
            OP_GT:   simple_next = word_t'(gt);
            OP_GE:   simple_next = word_t'(!lt);
            OP_EQ:   simple_next = word_t'(eq);
            OP_NE:   simple_next = word_t'(!eq);
            OP_AND:  simple_next = in_lhs & in_rhs;
            OP_XOR:  simple_next = in_lhs ^ in_rhs;
            OP_OR:   simple_next = in_lhs | in_rhs;
            default: simple_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_op_reg     <= in_op;
            a_fault_reg  <= fault_next;
            a_neg_q_reg  <= in_lhs[DataWidth-1] ^ in_rhs[DataWidth-1];
            a_neg_r_reg  <= in_lhs[DataWidth-1];
            a_simple_reg <= simple_next;
            a_mag_a_reg  <= in_lhs[DataWidth-1] ? (~in_lhs + 1'b1) : in_lhs;
            a_mag_b_reg  <= in_rhs[DataWidth-1] ? (~in_rhs + 1'b1) : in_rhs;
            a_pp_ll_reg  <= pp_ll_next;
            a_pp_lh_reg  <= pp_lh_next;
            a_pp_hl_reg  <= pp_hl_next;
        end
    end

    always_comb
    begin
        b_item_next.valid = a_valid_reg;
        b_item_next.op    = a_op_reg;
        b_item_next.fault = a_fault_reg;
        b_item_next.neg_q = a_neg_q_reg;
        b_item_next.neg_r = a_neg_r_reg;
        b_item_next.res   = (a_op_reg == OP_MUL)
            ? a_pp_ll_reg + {a_pp_lh_reg + a_pp_hl_reg, {Half{1'b0}}}
            : a_simple_reg;
        b_item_next.rem   = '0;
        b_item_next.quo   = a_mag_a_reg;
        b_item_next.dsr   = a_mag_b_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b_valid_reg <= b_item_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_item_reg <= b_item_next;
        end
    end

    always_comb
    begin
        out_item       = b_item_reg;
        out_item.valid = b_valid_reg;
    end

endmodule

// ===== design/sia_div_stage.sv =====
`timescale 1ns / 1ps
// One stage of the pipelined restoring divider: produces one quotient bit.
// Depends on sia_pkg.
module sia_div_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  sia_pkg::div_t  in_item,
    output sia_pkg::div_t  out_item
);
    import sia_pkg::*;

    logic                 valid_reg;
    div_t                 item_reg;
    div_t                 item_next;
    logic [DataWidth:0]   trial;
    logic [DataWidth:0]   diff;

    assign trial = {in_item.rem, in_item.quo[DataWidth-1]};
    assign diff  = trial - {1'b0, in_item.dsr};

    always_comb
    begin
        item_next = in_item;
        if (!diff[DataWidth])
        begin
            item_next.rem = diff[DataWidth-1:0];
        end
        else
        begin
            item_next.rem = trial[DataWidth-1:0];
        end
        item_next.quo = {in_item.quo[DataWidth-2:0], !diff[DataWidth]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= item_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
        end
    end

    always_comb
    begin
        out_item       = item_reg;
        out_item.valid = valid_reg;
    end

endmodule

// ===== design/signed_integer_binop_alu.sv =====
`timescale 1ns / 1ps
// Top level of the signed 64-bit integer ALU.
// Depends on sia_pkg, sia_front and sia_div_stage.

// The ALU takes one operation per cycle unless the result side stalls. Each
// result passes two front stages (decode, the simple operations and the
// partial products of the multiplier), 64 divider stages that each resolve
// one quotient bit, and the output register. Every operation travels the
// whole pipeline, so results leave in order. When the result side stalls,
// the whole pipeline holds and s_tready is low.
module signed_integer_binop_alu (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // op[3:0], lhs[67:4], rhs[131:68], zero fill.
    input  logic [sia_pkg::InBytes*8-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // value[63:0], fault[65:64], zero fill.
    output logic [sia_pkg::OutBytes*8-1:0] m_tdata
);
    import sia_pkg::*;

    logic   en;
    div_t   chain [0:DivSteps];
    div_t   last;
    logic   out_valid_reg;
    word_t  value_reg;
    word_t  value_next;
    fault_t fault_reg;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    sia_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_tvalid),
        .in_op    (op_t'(s_tdata[3:0])),
        .in_lhs   (s_tdata[DataWidth+3:4]),
        .in_rhs   (s_tdata[2*DataWidth+3:DataWidth+4]),
        .out_item (chain[0])
    );

    for (genvar i = 0; i < DivSteps; i++)
    begin : g_div
        sia_div_stage u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_item  (chain[i]),
            .out_item (chain[i+1])
        );
    end

    assign last = chain[DivSteps];

    always_comb
    begin
        if (last.fault != FAULT_NONE)
        begin
            value_next = '0;
        end
        else if (last.op == OP_DIV)
        begin
            value_next = last.neg_q ? (~last.quo + 1'b1) : last.quo;
        end
        else if (last.op == OP_REM)
        begin
            value_next = last.neg_r ? (~last.rem + 1'b1) : last.rem;
        end
        else
        begin
            value_next = last.res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= last.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            value_reg <= value_next;
            fault_reg <= last.fault;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OutBytes*8-DataWidth-2){1'b0}}, fault_reg, value_reg};

    a_fault_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[DataWidth+1:DataWidth] != FAULT_NONE)
            |-> m_tdata[DataWidth-1:0] == '0)
        else $error("Faulted result carries a nonzero value.");

    a_fault_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[DataWidth+1:DataWidth] != 2'd3)
        else $error("Unused fault code on the result.");

    a_fault_only_div: assert property (@(posedge clk) disable iff (!rst_n)
        (last.valid && last.fault != FAULT_NONE)
            |-> (last.op == OP_DIV || last.op == OP_REM))
        else $error("Fault raised for an operation other than div or rem.");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!en) |=> $stable(last))
        else $error("Pipeline moved while the result side stalled.");

endmodule
